### rtl/core/elgs_pkg.sv
// Shared definitions for the edge list graph store: operation codes,
// field widths and the default table depth. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package elgs_pkg;

  // Default number of edges the table holds.
  localparam int MAX_EDGES_DEFAULT = 32;

  // Field widths.
  localparam int OP_W     = 3;
  localparam int VERTEX_W = 8;
  localparam int ANSWER_W = 8;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_ADD = 3'd0;
  localparam logic [OP_W-1:0] OP_ADJ = 3'd1;
  localparam logic [OP_W-1:0] OP_DEG = 3'd2;
  localparam logic [OP_W-1:0] OP_NBR = 3'd3;
  localparam logic [OP_W-1:0] OP_CLR = 3'd4;

endpackage : elgs_pkg

`default_nettype wire

### rtl/core/elgs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module elgs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule : elgs_ram

`default_nettype wire

### rtl/core/edge_list_graph_store_top.sv
// Top level of the edge list graph store: control, scan logic and result registers.
// Depends on elgs_pkg and elgs_ram.
//
// An item is taken when start is high and busy is low. Add and clear finish in the
// cycle they are taken, keep busy low, and show their single result in the next
// cycle, so one may follow every cycle. Adjacency, degree and neighbor queries read
// the edge RAM once per stored edge, one entry per cycle, while busy is high; the
// registered read data is matched, and a flush state then shows the final result.
// With an empty table a query goes straight to the flush state. Each result is
// shown for exactly one cycle with result_valid high, and the receiver cannot
// hold it off. Neighbor results trail the RAM read by one matching edge, so that
// the final one can carry last_result. Unknown operation codes are dropped without
// a result.
`timescale 1ns / 1ps
`default_nettype none

module edge_list_graph_store_top
  import elgs_pkg::*;
#(
  parameter int MAX_EDGES = MAX_EDGES_DEFAULT
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [OP_W-1:0]     operation,
  input  wire logic [VERTEX_W-1:0] first_vertex,
  input  wire logic [VERTEX_W-1:0] second_vertex,
  output logic                     result_valid,
  output logic                     status,
  output logic [ANSWER_W-1:0]      answer,
  output logic                     empty_list,
  output logic                     last_result
);

  localparam int CNT_W  = $clog2(MAX_EDGES + 1);
  localparam int ADDR_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ENTRY_W = 2 * VERTEX_W;

  // Controller states.
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  logic [1:0]          state;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    issue_idx;
  logic                rd_valid;
  logic                rd_last;
  logic [OP_W-1:0]     op_q;
  logic [VERTEX_W-1:0] a_q;
  logic [VERTEX_W-1:0] b_q;
  logic                found;
  logic [CNT_W-1:0]    deg;
  logic [VERTEX_W-1:0] pend;
  logic                have_pend;

  logic                accept;
  logic                full;
  logic                issuing;
  logic                issue_last;
  logic                wr_en;
  logic [ENTRY_W-1:0]  rd_data;
  logic [VERTEX_W-1:0] ent_s;
  logic [VERTEX_W-1:0] ent_e;
  logic                hit_s;
  logic                hit_e;
  logic                adj_hit;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign full   = (count == CNT_W'(MAX_EDGES));
  assign wr_en  = accept && (operation == OP_ADD) && !full;

  // One RAM read is issued per cycle while entries remain.
  assign issuing    = (state == ST_SCAN) && (issue_idx < count);
  assign issue_last = (CNT_W'(issue_idx + 1'b1) == count);

  // Edge table: start vertex in the upper byte, end vertex in the lower.
  elgs_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_EDGES)
  ) u_edge_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count[ADDR_W-1:0]),
    .wr_data ({first_vertex, second_vertex}),
    .rd_addr (issue_idx[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  // Match logic on the entry that comes back from the RAM.
  assign ent_s   = rd_data[ENTRY_W-1:VERTEX_W];
  assign ent_e   = rd_data[VERTEX_W-1:0];
  assign hit_s   = (ent_s == a_q);
  assign hit_e   = (ent_e == a_q);
  assign adj_hit = (hit_s && (ent_e == b_q)) || ((ent_s == b_q) && hit_e);

  // Controller, accumulators and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      count        <= '0;
      issue_idx    <= '0;
      rd_valid     <= 1'b0;
      rd_last      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      rd_valid     <= issuing;
      rd_last      <= issuing && issue_last;
      if (issuing) begin
        issue_idx <= CNT_W'(issue_idx + 1'b1);
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (operation)
              OP_ADD: begin
                result_valid <= 1'b1;
                status       <= full;
                answer       <= '0;
                empty_list   <= 1'b0;
                last_result  <= 1'b1;
                if (!full) begin
                  count <= CNT_W'(count + 1'b1);
                end
              end
              OP_CLR: begin
                count        <= '0;
                result_valid <= 1'b1;
                status       <= 1'b0;
                answer       <= '0;
                empty_list   <= 1'b0;
                last_result  <= 1'b1;
              end
              OP_ADJ, OP_DEG, OP_NBR: begin
                op_q      <= operation;
                a_q       <= first_vertex;
                b_q       <= second_vertex;
                issue_idx <= '0;
                found     <= 1'b0;
                deg       <= '0;
                have_pend <= 1'b0;
                state     <= (count == '0) ? ST_FLUSH : ST_SCAN;
              end
              default: begin
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (rd_valid) begin
            if (adj_hit) begin
              found <= 1'b1;
            end
            if (hit_s || hit_e) begin
              deg <= CNT_W'(deg + 1'b1);
            end
            // Neighbor listing: release the held neighbor once another is found.
            if ((op_q == OP_NBR) && (hit_s || hit_e)) begin
              if (have_pend) begin
                result_valid <= 1'b1;
                status       <= 1'b0;
                answer       <= pend;
                empty_list   <= 1'b0;
                last_result  <= 1'b0;
              end
              pend      <= hit_s ? ent_e : ent_s;
              have_pend <= 1'b1;
            end
            if (rd_last) begin
              state <= ST_FLUSH;
            end
          end
        end
        ST_FLUSH: begin
          result_valid <= 1'b1;
          status       <= 1'b0;
          last_result  <= 1'b1;
          empty_list   <= 1'b0;
          case (op_q)
            OP_ADJ: answer <= ANSWER_W'(found);
            OP_DEG: answer <= ANSWER_W'(deg);
            OP_NBR: begin
              answer     <= have_pend ? pend : '0;
              empty_list <= !have_pend;
            end
            default: answer <= '0;
          endcase
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule : edge_list_graph_store_top

`default_nettype wire

### rtl/core/elgs_checker.sv
// Port-level checks for the edge list graph store, bound to the top level.
// Depends on elgs_pkg and edge_list_graph_store_top.
`timescale 1ns / 1ps
`default_nettype none

module elgs_checker
  import elgs_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                start,
  input wire logic                busy,
  input wire logic [OP_W-1:0]     operation,
  input wire logic                result_valid,
  input wire logic                status,
  input wire logic [ANSWER_W-1:0] answer,
  input wire logic                empty_list,
  input wire logic                last_result
);

  // An add or clear item yields its single result in the next cycle.
  a_short_op_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (operation == OP_ADD || operation == OP_CLR))
      |=> (result_valid && last_result))
    else $error("add or clear item gave no final result in the next cycle");

  // A query item holds the block busy in the following cycle.
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (operation == OP_ADJ || operation == OP_DEG ||
                        operation == OP_NBR))
      |=> busy)
    else $error("query item did not hold the block busy");

  // More results of the same item follow while the block is still busy.
  a_more_results_busy: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !last_result) |-> busy)
    else $error("non-final result shown while the block is idle");

  // A refused add gives a single plain result.
  a_overflow_shape: assert property (@(posedge clk) disable iff (rst)
    (result_valid && status) |-> (last_result && !empty_list && answer == '0))
    else $error("overflow result has wrong shape");

  // An empty neighbor listing is a single final result with a zero answer.
  a_empty_shape: assert property (@(posedge clk) disable iff (rst)
    (result_valid && empty_list) |-> (last_result && answer == '0 && !status))
    else $error("empty neighbor result has wrong shape");

endmodule : elgs_checker

bind edge_list_graph_store_top elgs_checker u_elgs_checker (.*);

`default_nettype wire

### tb/graph_result_checker.sv
// Checker for the edge list graph store: keeps its own copy of the edge table,
// predicts the results of every accepted item and compares them as they appear.
// Depends on elgs_pkg for operation codes and field widths.
`timescale 1ns / 1ps

module graph_result_checker
  import elgs_pkg::*;
#(
  parameter int MAX_EDGES = MAX_EDGES_DEFAULT
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic                busy,
  input  wire logic [OP_W-1:0]     operation,
  input  wire logic [VERTEX_W-1:0] first_vertex,
  input  wire logic [VERTEX_W-1:0] second_vertex,
  input  wire logic                result_valid,
  input  wire logic                status,
  input  wire logic [ANSWER_W-1:0] answer,
  input  wire logic                empty_list,
  input  wire logic                last_result,
  output int                       mismatch_total,
  output int                       results_pending
);

  typedef struct packed {
    logic                status;
    logic [ANSWER_W-1:0] answer;
    logic                empty_list;
    logic                last_result;
  } graph_result_t;

  // Shadow copy of the edge table, in insertion order.
  logic [VERTEX_W-1:0] edge_from [MAX_EDGES];
  logic [VERTEX_W-1:0] edge_to   [MAX_EDGES];
  int                  edges_held;

  // Results still owed by the block, oldest first.
  graph_result_t owed_results [$];

  function automatic graph_result_t pack_result(input logic st, input logic [ANSWER_W-1:0] ans,
                                                input logic emp, input logic lst);
    graph_result_t r;
    r.status      = st;
    r.answer      = ans;
    r.empty_list  = emp;
    r.last_result = lst;
    return r;
  endfunction

  // Apply one item to the shadow table and queue the results it causes.
  function automatic void apply_item(input logic [OP_W-1:0] op, input logic [VERTEX_W-1:0] a,
                                     input logic [VERTEX_W-1:0] b);
    int            touching;
    logic          linked;
    logic          have_prior;
    graph_result_t prior;
    touching   = 0;
    linked     = 1'b0;
    have_prior = 1'b0;
    prior      = '0;
    case (op)
      OP_ADD: begin
        if (edges_held >= MAX_EDGES) begin
          owed_results.push_back(pack_result(1'b1, '0, 1'b0, 1'b1));
        end else begin
          edge_from[edges_held] = a;
          edge_to[edges_held]   = b;
          edges_held++;
          owed_results.push_back(pack_result(1'b0, '0, 1'b0, 1'b1));
        end
      end
      OP_ADJ: begin
        for (int i = 0; i < edges_held; i++) begin
          if ((edge_from[i] == a && edge_to[i] == b) || (edge_from[i] == b && edge_to[i] == a))
            linked = 1'b1;
        end
        owed_results.push_back(pack_result(1'b0, ANSWER_W'(linked), 1'b0, 1'b1));
      end
      OP_DEG: begin
        // A self-loop matches both ends but counts once.
        for (int i = 0; i < edges_held; i++) begin
          if (edge_from[i] == a || edge_to[i] == a)
            touching++;
        end
        owed_results.push_back(pack_result(1'b0, ANSWER_W'(touching), 1'b0, 1'b1));
      end
      OP_NBR: begin
        // Hold each neighbor back by one so the final one can be marked last.
        for (int i = 0; i < edges_held; i++) begin
          if (edge_from[i] == a || edge_to[i] == a) begin
            if (have_prior)
              owed_results.push_back(prior);
            prior = pack_result(1'b0, (edge_from[i] == a) ? edge_to[i] : edge_from[i],
                                1'b0, 1'b0);
            have_prior = 1'b1;
          end
        end
        if (have_prior) begin
          prior.last_result = 1'b1;
          owed_results.push_back(prior);
        end else begin
          owed_results.push_back(pack_result(1'b0, '0, 1'b1, 1'b1));
        end
      end
      OP_CLR: begin
        edges_held = 0;
        owed_results.push_back(pack_result(1'b0, '0, 1'b0, 1'b1));
      end
      default: begin
        // Unknown operations are dropped without a result.
      end
    endcase
  endfunction

  // Results shown at this edge belong to items taken earlier, so compare before
  // predicting the item taken at the same edge.
  always @(posedge clk) begin
    graph_result_t seen;
    graph_result_t want;
    if (rst) begin
      edges_held = 0;
      owed_results.delete();
    end else begin
      if (result_valid) begin
        seen = pack_result(status, answer, empty_list, last_result);
        if (owed_results.size() == 0) begin
          $error("result with none expected: status %0d answer %0d empty_list %0d last %0d",
                 seen.status, seen.answer, seen.empty_list, seen.last_result);
          mismatch_total++;
        end else begin
          want = owed_results.pop_front();
          if (seen.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, seen.status);
            mismatch_total++;
          end
          if (seen.answer !== want.answer) begin
            $error("answer: expected %0d, got %0d", want.answer, seen.answer);
            mismatch_total++;
          end
          if (seen.empty_list !== want.empty_list) begin
            $error("empty_list: expected %0d, got %0d", want.empty_list, seen.empty_list);
            mismatch_total++;
          end
          if (seen.last_result !== want.last_result) begin
            $error("last_result: expected %0d, got %0d", want.last_result, seen.last_result);
            mismatch_total++;
          end
        end
      end
      if (start && !busy)
        apply_item(operation, first_vertex, second_vertex);
    end
    results_pending = owed_results.size();
  end

endmodule : graph_result_checker

### tb/tb.sv
// Testbench top for the edge list graph store: clock, reset, directed and random
// items, and the verdict. Depends on elgs_pkg, edge_list_graph_store_top and
// graph_result_checker.
`timescale 1ns / 1ps

module tb;
  import elgs_pkg::*;

  localparam int MAX_EDGES    = MAX_EDGES_DEFAULT;
  localparam int RANDOM_ITEMS = 300;
  localparam int DRAIN_CYCLES = MAX_EDGES + 8;

  logic                clk = 1'b0;
  logic                rst;
  logic                start;
  logic                busy;
  logic [OP_W-1:0]     operation;
  logic [VERTEX_W-1:0] first_vertex;
  logic [VERTEX_W-1:0] second_vertex;
  logic                result_valid;
  logic                status;
  logic [ANSWER_W-1:0] answer;
  logic                empty_list;
  logic                last_result;
  int                  mismatch_total;
  int                  results_pending;

  // Random stimulus state.
  int                  burst_left;
  int                  vertex_base;
  int                  add_pct;
  int                  episode_len;
  int                  episode;
  int                  queries_sent;
  logic [OP_W-1:0]     next_op;
  logic [VERTEX_W-1:0] next_a;

  edge_list_graph_store_top #(
    .MAX_EDGES(MAX_EDGES)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .operation    (operation),
    .first_vertex (first_vertex),
    .second_vertex(second_vertex),
    .result_valid (result_valid),
    .status       (status),
    .answer       (answer),
    .empty_list   (empty_list),
    .last_result  (last_result)
  );

  graph_result_checker #(
    .MAX_EDGES(MAX_EDGES)
  ) u_checker (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .operation      (operation),
    .first_vertex   (first_vertex),
    .second_vertex  (second_vertex),
    .result_valid   (result_valid),
    .status         (status),
    .answer         (answer),
    .empty_list     (empty_list),
    .last_result    (last_result),
    .mismatch_total (mismatch_total),
    .results_pending(results_pending)
  );

  // 2 ns clock period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Present one item at the falling edge and hold it until the block takes it.
  task automatic issue_item(input logic [OP_W-1:0] op, input logic [VERTEX_W-1:0] a,
                            input logic [VERTEX_W-1:0] b);
    @(negedge clk);
    start         <= 1'b1;
    operation     <= op;
    first_vertex  <= a;
    second_vertex <= b;
    do @(posedge clk); while (busy);
  endtask

  // Leave start low for a number of cycles, with noise on the fields.
  task automatic hold_off(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      start         <= 1'b0;
      operation     <= OP_W'($urandom);
      first_vertex  <= VERTEX_W'($urandom);
      second_vertex <= VERTEX_W'($urandom);
    end
  endtask

  // Stop sending until every expected result has been seen.
  task automatic wait_for_results();
    hold_off(1);
    while (results_pending != 0)
      @(negedge clk);
  endtask

  // Mostly vertices from a small window so edges collide, sometimes any value.
  function automatic logic [VERTEX_W-1:0] pick_vertex();
    if ($urandom_range(0, 99) < 70)
      return VERTEX_W'(vertex_base + $urandom_range(0, 5));
    return VERTEX_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [OP_W-1:0] pick_operation();
    int roll;
    if ($urandom_range(0, 99) < add_pct)
      return OP_ADD;
    roll = $urandom_range(0, 99);
    if (roll < 30)
      return OP_ADJ;
    if (roll < 55)
      return OP_DEG;
    if (roll < 90)
      return OP_NBR;
    if (roll < 94)
      return OP_CLR;
    return OP_W'($urandom_range(5, 7));
  endfunction

  // Bursts of items with random gaps; about half the bursts follow without a gap.
  task automatic paced_item(input logic [OP_W-1:0] op, input logic [VERTEX_W-1:0] a,
                            input logic [VERTEX_W-1:0] b);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 1) == 1)
        hold_off($urandom_range(1, 6));
    end
    burst_left--;
    issue_item(op, a, b);
  endtask

  initial begin
    rst           = 1'b1;
    start         = 1'b0;
    operation     = OP_ADD;
    first_vertex  = '0;
    second_vertex = '0;
    burst_left    = 0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    hold_off(2);

    // Directed: extreme vertices, duplicates, a self-loop and every operation.
    issue_item(OP_ADD, 8'd0, 8'd255);
    issue_item(OP_ADD, 8'd255, 8'd0);
    issue_item(OP_ADD, 8'd7, 8'd7);
    issue_item(OP_ADD, 8'd0, 8'd7);
    issue_item(OP_ADJ, 8'd255, 8'd0);
    issue_item(OP_ADJ, 8'd0, 8'd255);
    hold_off(1);
    issue_item(OP_ADJ, 8'd7, 8'd7);
    issue_item(OP_ADJ, 8'd0, 8'd0);
    issue_item(OP_DEG, 8'd0, 8'd0);
    issue_item(OP_DEG, 8'd7, 8'd255);
    issue_item(OP_DEG, 8'd255, 8'd0);
    issue_item(OP_NBR, 8'd0, 8'd255);
    hold_off(3);
    issue_item(OP_NBR, 8'd7, 8'd0);
    issue_item(OP_NBR, 8'd100, 8'd0);
    // Unknown operation codes produce nothing.
    issue_item(OP_W'(5), 8'd0, 8'd255);
    issue_item(OP_W'(6), 8'd255, 8'd255);
    issue_item(OP_W'(7), 8'd0, 8'd0);
    issue_item(OP_DEG, 8'd128, 8'd0);
    issue_item(OP_CLR, 8'd255, 8'd255);
    issue_item(OP_NBR, 8'd0, 8'd0);
    issue_item(OP_ADJ, 8'd0, 8'd255);
    issue_item(OP_DEG, 8'd0, 8'd0);

    // Random episodes, each from an empty table. The first one is add-heavy
    // and long enough to fill the table and overflow it.
    queries_sent = 0;
    episode      = 0;
    while (queries_sent < RANDOM_ITEMS) begin
      vertex_base = $urandom_range(0, 250);
      add_pct     = (episode == 0) ? 90 : $urandom_range(25, 85);
      episode_len = (episode == 0) ? 50 : $urandom_range(10, 60);
      paced_item(OP_CLR, pick_vertex(), pick_vertex());
      queries_sent++;
      for (int k = 0; k < episode_len && queries_sent < RANDOM_ITEMS; k++) begin
        next_op = pick_operation();
        next_a  = pick_vertex();
        paced_item(next_op, next_a, ($urandom_range(0, 9) == 0) ? next_a : pick_vertex());
        if (next_op <= OP_CLR)
          queries_sent++;
      end
      // Let the block drain completely once before going on.
      if (episode == 2)
        wait_for_results();
      episode++;
    end

    wait_for_results();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_total == 0 && results_pending == 0)
      $display("PASS edge_list_graph_store_top");
    else
      $display("FAIL edge_list_graph_store_top");
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #400000;
    $display("FAIL edge_list_graph_store_top");
    $finish;
  end

endmodule : tb
